// ===== rtl/core/tmg_pkg.sv =====
package tmg_pkg;

	localparam int GAMMA_TABLE_BITS = 10;
	localparam int LUT_SIZE = 1 << GAMMA_TABLE_BITS;

	localparam int DIV_STEPS = 32;
	localparam int RECIP_STEPS = 17;
	localparam int MERGE_LAT = RECIP_STEPS + 5;
	localparam int PIPE_LAT = DIV_STEPS + MERGE_LAT + 2;

	localparam int CFG_INDEX_W = 4;
	localparam int BIG_W = 192;

	localparam logic [31:0] ONE_Q16 = 32'd65536;
	localparam logic [15:0] W_RED = 16'd19595;
	localparam logic [15:0] W_GREEN = 16'd38470;
	localparam logic [15:0] W_BLUE = 16'd7471;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_EPOCH_COUNT = CFG_INDEX_W'(0),
		REG_EXPOSURE_GAIN = CFG_INDEX_W'(1)
	} cfg_reg_t;

	typedef struct packed {
		logic [31:0] red_sum;
		logic [31:0] green_sum;
		logic [31:0] blue_sum;
	} in_item_t;

	typedef struct packed {
		logic [7:0] red_byte;
		logic [7:0] green_byte;
		logic [7:0] blue_byte;
	} out_item_t;

	typedef logic [LUT_SIZE-1:0][7:0] gamma_lut_t;

	function automatic logic [BIG_W-1:0] big_pow(input int unsigned base, input int unsigned n);
		logic [BIG_W-1:0] acc;
		acc = BIG_W'(1);
		for (int unsigned j = 0; j < n; j++) begin
			acc = acc * BIG_W'(base);
		end
		return acc;
	endfunction

	// Entry i is the largest k with (2k-1)^11 * N^5 <= i^5 * 510^11.
	function automatic gamma_lut_t gamma_build();
		gamma_lut_t lut;
		logic [BIG_W-1:0] c510;
		logic [BIG_W-1:0] rhs;
		logic [BIG_W-1:0] lhs;
		int unsigned k;
		logic done;
		c510 = big_pow(510, 11);
		k = 0;
		for (int unsigned i = 0; i < LUT_SIZE; i++) begin
			rhs = c510 * big_pow(i, 5);
			done = 1'b0;
			while (!done && k < 255) begin
				lhs = big_pow(2 * k + 1, 11) << (5 * GAMMA_TABLE_BITS);
				if (lhs > rhs) begin
					done = 1'b1;
				end else begin
					k = k + 1;
				end
			end
			lut[i] = 8'(k);
		end
		return lut;
	endfunction

	localparam gamma_lut_t GAMMA_LUT = gamma_build();

endpackage

// ===== rtl/core/tmg_div_lane.sv =====
module tmg_div_lane
	import tmg_pkg::*;
(
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] dividend,
	input  logic [15:0] divisor,
	output logic [31:0] quotient
);

	logic [15:0] rem_s [DIV_STEPS-1];
	logic [31:0] word_s [DIV_STEPS];

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		logic [15:0] rem_in;
		logic [31:0] word_in;
		logic [16:0] part;
		logic [16:0] diff;
		logic        ge;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign word_in = dividend;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign word_in = word_s[k-1];
		end

		assign part = {rem_in, word_in[31]};
		assign ge = part >= {1'b0, divisor};
		assign diff = part - {1'b0, divisor};

		always_ff @(posedge clk) begin
			if (en) begin
				word_s[k] <= {word_in[30:0], ge};
			end
		end

		if (k < DIV_STEPS - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= ge ? diff[15:0] : part[15:0];
				end
			end
		end
	end

	assign quotient = word_s[DIV_STEPS-1];

endmodule

// ===== rtl/core/tmg_merge.sv =====
module tmg_merge
	import tmg_pkg::*;
(
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] mean_red,
	input  logic [31:0] mean_green,
	input  logic [31:0] mean_blue,
	input  logic [31:0] gain,
	output logic [31:0] scale
);

	logic [47:0] pr_s1;
	logic [47:0] pg_s1;
	logic [47:0] pb_s1;
	logic [47:0] lum_sum;
	logic [31:0] lum_s2;
	logic [63:0] lum_gain;
	logic [47:0] scaled_s3;
	logic [48:0] den_s4;
	logic [48:0] rem_s [RECIP_STEPS-1];
	logic [48:0] den_s [RECIP_STEPS-1];
	logic [RECIP_STEPS-1:0] q_s [RECIP_STEPS];
	logic [48:0] gain_fac;
	logic [31:0] scale_s;

	assign lum_sum = pr_s1 + pg_s1 + pb_s1;
	assign lum_gain = 64'(lum_s2) * 64'(gain);

	always_ff @(posedge clk) begin
		if (en) begin
			pr_s1 <= 48'(mean_red) * 48'(W_RED);
			pg_s1 <= 48'(mean_green) * 48'(W_GREEN);
			pb_s1 <= 48'(mean_blue) * 48'(W_BLUE);
			lum_s2 <= lum_sum[47:16];
			scaled_s3 <= lum_gain[63:16];
			den_s4 <= 49'(scaled_s3) + 49'(ONE_Q16);
		end
	end

	// The upper dividend bits of 2^32 leave a remainder of 2^15 before the
	// first quotient bit that can be nonzero.
	for (genvar k = 0; k < RECIP_STEPS; k++) begin : g_step
		logic [48:0] rem_in;
		logic [48:0] den_in;
		logic [RECIP_STEPS-1:0] q_in;
		logic [49:0] part;
		logic [49:0] diff;
		logic        ge;

		if (k == 0) begin : g_first
			assign rem_in = 49'(1) << 15;
			assign den_in = den_s4;
			assign q_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
			assign q_in = q_s[k-1];
		end

		assign part = {rem_in, 1'b0};
		assign ge = part >= {1'b0, den_in};
		assign diff = part - {1'b0, den_in};

		always_ff @(posedge clk) begin
			if (en) begin
				q_s[k] <= {q_in[RECIP_STEPS-2:0], ge};
			end
		end

		if (k < RECIP_STEPS - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= ge ? diff[48:0] : part[48:0];
					den_s[k] <= den_in;
				end
			end
		end
	end

	assign gain_fac = 49'(gain) * 49'(q_s[RECIP_STEPS-1]);

	always_ff @(posedge clk) begin
		if (en) begin
			scale_s <= gain_fac[47:16];
		end
	end

	assign scale = scale_s;

endmodule

// ===== rtl/core/tmg_enc_lane.sv =====
module tmg_enc_lane
	import tmg_pkg::*;
(
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] mean,
	input  logic [31:0] scale,
	output logic [7:0]  pix
);

	logic [31:0] mean_s [MERGE_LAT];
	logic [63:0] prod_s1;
	logic [7:0]  pix_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			mean_s[0] <= mean;
			for (int j = 1; j < MERGE_LAT; j++) begin
				mean_s[j] <= mean_s[j-1];
			end
			prod_s1 <= 64'(mean_s[MERGE_LAT-1]) * 64'(scale);
			if (|prod_s1[63:32]) begin
				pix_s2 <= 8'hFF;
			end else begin
				pix_s2 <= GAMMA_LUT[prod_s1[31 -: GAMMA_TABLE_BITS]];
			end
		end
	end

	assign pix = pix_s2;

endmodule

// ===== rtl/core/tone_map_gamma_pixel.sv =====
// Throughput: one item per cycle while the skid register is not full, set by
// the 32-step channel dividers, the 17-step reciprocal pipeline and the gamma
// table read, all fully pipelined.
// Reset: epoch_count returns to 1 and exposure_gain to 1.0; the pipeline and
// output buffer are emptied at once. The gamma table is constant logic.
module tone_map_gamma_pixel
	import tmg_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  in_item_t               in_item,
	output logic                   out_valid,
	input  logic                   out_stall,
	output out_item_t              out_item,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0]            cfg_data
);

	logic [15:0] divisor_q;
	logic [31:0] gain_q;
	logic        en;
	logic        vld_s [PIPE_LAT];
	logic [31:0] mean_red;
	logic [31:0] mean_green;
	logic [31:0] mean_blue;
	logic [31:0] scale;
	logic [7:0]  pix_red;
	logic [7:0]  pix_green;
	logic [7:0]  pix_blue;
	out_item_t   pix_item;
	logic        push;
	logic        take;
	logic        out_valid_q;
	out_item_t   out_item_q;
	logic        skid_full_q;
	out_item_t   skid_item_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divisor_q <= 16'd1;
			gain_q <= ONE_Q16;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_EPOCH_COUNT: begin
					divisor_q <= (cfg_data[15:0] == 16'd0) ? 16'd1 : cfg_data[15:0];
				end
				REG_EXPOSURE_GAIN: begin
					gain_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	assign en = !skid_full_q;
	assign in_stall = skid_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < PIPE_LAT; j++) begin
				vld_s[j] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int j = 1; j < PIPE_LAT; j++) begin
				vld_s[j] <= vld_s[j-1];
			end
		end
	end

	tmg_div_lane u_div_red (
		.clk      (clk),
		.en       (en),
		.dividend (in_item.red_sum),
		.divisor  (divisor_q),
		.quotient (mean_red)
	);

	tmg_div_lane u_div_green (
		.clk      (clk),
		.en       (en),
		.dividend (in_item.green_sum),
		.divisor  (divisor_q),
		.quotient (mean_green)
	);

	tmg_div_lane u_div_blue (
		.clk      (clk),
		.en       (en),
		.dividend (in_item.blue_sum),
		.divisor  (divisor_q),
		.quotient (mean_blue)
	);

	tmg_merge u_merge (
		.clk        (clk),
		.en         (en),
		.mean_red   (mean_red),
		.mean_green (mean_green),
		.mean_blue  (mean_blue),
		.gain       (gain_q),
		.scale      (scale)
	);

	tmg_enc_lane u_enc_red (
		.clk   (clk),
		.en    (en),
		.mean  (mean_red),
		.scale (scale),
		.pix   (pix_red)
	);

	tmg_enc_lane u_enc_green (
		.clk   (clk),
		.en    (en),
		.mean  (mean_green),
		.scale (scale),
		.pix   (pix_green)
	);

	tmg_enc_lane u_enc_blue (
		.clk   (clk),
		.en    (en),
		.mean  (mean_blue),
		.scale (scale),
		.pix   (pix_blue)
	);

	assign pix_item = '{red_byte: pix_red, green_byte: pix_green, blue_byte: pix_blue};

	// A finished item goes to the output register when it is free and to the
	// skid register otherwise; a full skid register halts the pipeline.
	assign push = en && vld_s[PIPE_LAT-1];
	assign take = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			if (take) begin
				skid_full_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_valid_q || take) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_full_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_full_q) begin
			if (take) begin
				out_item_q <= skid_item_q;
			end
		end else if (push) begin
			if (!out_valid_q || take) begin
				out_item_q <= pix_item;
			end else begin
				skid_item_q <= pix_item;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_item_q;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full_q |-> out_valid_q)
		else $error("skid register holds an item while the output register is empty");

	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full_q && out_stall |=> skid_full_q)
		else $error("skid register emptied while the output was stalled");

	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> out_valid_q)
		else $error("finished item was not captured by the output buffer");

endmodule

// ===== tb/tone_map_gamma_pixel_tb.sv =====
`timescale 1ns / 1ps

module tone_map_gamma_pixel_tb;
	import tmg_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_item;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	tone_map_gamma_pixel uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	logic [7:0] gamma_table [LUT_SIZE];
	logic [15:0] epoch_setting = 16'd1;
	logic [31:0] gain_setting = ONE_Q16;

	in_item_t pending_pixels [$];
	out_item_t expected_bytes [$];
	out_item_t wanted;

	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	bit item_taken = 1'b0;
	int mismatches = 0;
	int pixels_accepted = 0;
	int pixels_checked = 0;
	int register_writes = 0;

	function automatic logic [191:0] raise(input int unsigned base, input int unsigned exponent);
		logic [191:0] acc;
		acc = 192'd1;
		repeat (exponent) acc = acc * 192'(base);
		return acc;
	endfunction

	// Entry i is the largest code k for which (2k-1)^11 * N^5 <= i^5 * 510^11.
	function automatic void build_gamma_table();
		logic [191:0] scale_510;
		logic [191:0] bound;
		int unsigned code;
		scale_510 = raise(510, 11);
		code = 0;
		for (int unsigned idx = 0; idx < LUT_SIZE; idx++) begin
			bound = raise(idx, 5) * scale_510;
			while (code < 255 &&
					(raise(2 * code + 1, 11) << (5 * GAMMA_TABLE_BITS)) <= bound)
				code++;
			gamma_table[idx] = 8'(code);
		end
	endfunction

	function automatic logic [7:0] encode_byte(input logic [31:0] mean, input logic [63:0] mult);
		logic [63:0] upper;
		logic [63:0] lower;
		logic [63:0] level;
		upper = 64'(mean) * (mult >> 16);
		lower = 64'(mean) * (mult & 64'hFFFF);
		if (upper >= 64'(ONE_Q16))
			return 8'd255;
		level = ((upper << 16) + lower) >> 16;
		if (level >= 64'(ONE_Q16))
			return 8'd255;
		return gamma_table[level[15 -: GAMMA_TABLE_BITS]];
	endfunction

	function automatic out_item_t predict_display(input in_item_t px);
		logic [31:0] divisor;
		logic [31:0] mean_r;
		logic [31:0] mean_g;
		logic [31:0] mean_b;
		logic [63:0] luma;
		logic [63:0] scaled;
		logic [63:0] atten;
		logic [63:0] mult;
		out_item_t res;
		divisor = (epoch_setting == 16'd0) ? 32'd1 : 32'(epoch_setting);
		mean_r = px.red_sum / divisor;
		mean_g = px.green_sum / divisor;
		mean_b = px.blue_sum / divisor;
		luma = (64'(W_RED) * 64'(mean_r) + 64'(W_GREEN) * 64'(mean_g)
			+ 64'(W_BLUE) * 64'(mean_b)) >> 16;
		scaled = (luma * 64'(gain_setting)) >> 16;
		atten = (64'd1 << 32) / (64'(ONE_Q16) + scaled);
		mult = (64'(gain_setting) * atten) >> 16;
		res.red_byte = encode_byte(mean_r, mult);
		res.green_byte = encode_byte(mean_g, mult);
		res.blue_byte = encode_byte(mean_b, mult);
		return res;
	endfunction

	function automatic logic [31:0] random_sum();
		if ($urandom_range(0, 3) == 0)
			return $urandom;
		return $urandom >> $urandom_range(0, 31);
	endfunction

	task automatic add_pixel(input in_item_t px);
		pending_pixels = {pending_pixels, px};
	endtask

	task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_EPOCH_COUNT: begin
				epoch_setting = value[15:0];
			end
			REG_EXPOSURE_GAIN: begin
				gain_setting = value;
			end
			default: begin
			end
		endcase
		register_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (pending_pixels.size() != 0 || in_valid || expected_bytes.size() != 0)
			@(posedge clk);
	endtask

	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || item_taken) begin
				if (pending_pixels.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
					in_valid <= 1'b1;
					in_item <= pending_pixels.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
		end
	end

	always @(posedge clk) begin
		item_taken = arst_n && in_valid && !in_stall;
		if (item_taken) begin
			expected_bytes = {expected_bytes, predict_display(in_item)};
			pixels_accepted++;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (expected_bytes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected item at %0t: %h %h %h", $realtime,
						out_item.red_byte, out_item.green_byte, out_item.blue_byte);
			end else begin
				wanted = expected_bytes.pop_front();
				pixels_checked++;
				if (out_item.red_byte !== wanted.red_byte
						|| out_item.green_byte !== wanted.green_byte
						|| out_item.blue_byte !== wanted.blue_byte) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch at %0t: expected %h %h %h, got %h %h %h",
							$realtime, wanted.red_byte, wanted.green_byte,
							wanted.blue_byte, out_item.red_byte,
							out_item.green_byte, out_item.blue_byte);
				end
			end
		end
	end

	initial begin
		build_gamma_table();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int phase = 0; phase < 12; phase++) begin
			drain();
			case (phase)
				0: begin
				end
				1: begin
					write_register(REG_EPOCH_COUNT, 32'd0);
					write_register(CFG_INDEX_W'($urandom_range(REG_EXPOSURE_GAIN + 1,
						(1 << CFG_INDEX_W) - 1)), $urandom);
					write_register(REG_EXPOSURE_GAIN, ONE_Q16);
				end
				2: begin
					write_register(REG_EPOCH_COUNT, 32'hFFFF_FFFF);
					write_register(REG_EXPOSURE_GAIN, 32'hFFFF_FFFF);
				end
				3: begin
					write_register(REG_EPOCH_COUNT, 32'd1);
					write_register(REG_EXPOSURE_GAIN, 32'd0);
				end
				4: begin
					write_register(REG_EXPOSURE_GAIN, 32'hFFFF_FFFF);
				end
				default: begin
					write_register(REG_EPOCH_COUNT,
						$urandom_range(0, 65535) >> $urandom_range(0, 16));
					write_register(REG_EXPOSURE_GAIN, $urandom >> $urandom_range(0, 31));
					if ($urandom_range(0, 3) == 0)
						write_register(CFG_INDEX_W'($urandom_range(REG_EXPOSURE_GAIN + 1,
							(1 << CFG_INDEX_W) - 1)), $urandom);
				end
			endcase
			case (phase % 4)
				0: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 0;
				end
				1: begin
					sender_idle_pct = 59;
					receiver_stall_pct = 0;
				end
				2: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 59;
				end
				default: begin
					sender_idle_pct = 38;
					receiver_stall_pct = 38;
				end
			endcase
			if (phase == 0) begin
				add_pixel(in_item_t'{32'd0, 32'd0, 32'd0});
				add_pixel(in_item_t'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
				add_pixel(in_item_t'{32'hFFFF_FFFF, 32'd0, 32'd0});
				add_pixel(in_item_t'{32'd0, 32'hFFFF_FFFF, 32'd0});
				add_pixel(in_item_t'{32'd0, 32'd0, 32'hFFFF_FFFF});
				add_pixel(in_item_t'{ONE_Q16, ONE_Q16, ONE_Q16});
				add_pixel(in_item_t'{32'h8000, 32'h8000, 32'h8000});
				add_pixel(in_item_t'{32'd1, 32'd1, 32'd1});
				add_pixel(in_item_t'{ONE_Q16, 32'd0, 32'd0});
				add_pixel(in_item_t'{32'd0, 32'd0, 32'h0003_0000});
				add_pixel(in_item_t'{32'h0064_0000, ONE_Q16, 32'd0});
				add_pixel(in_item_t'{32'hFFFF_0000, 32'd1, 32'h8000_0000});
				add_pixel(in_item_t'{32'h0000_FFFF, 32'h5555_5555, 32'hAAAA_AAAA});
			end
			for (int n = 0; n < 150; n++) begin
				if ($urandom_range(0, 4) == 0) begin
					in_item_t gray;
					gray.red_sum = random_sum();
					gray.green_sum = gray.red_sum;
					gray.blue_sum = gray.red_sum;
					add_pixel(gray);
				end else begin
					add_pixel(in_item_t'{random_sum(), random_sum(), random_sum()});
				end
			end
		end

		drain();
		repeat (PIPE_LAT + 16) @(posedge clk);
		if (expected_bytes.size() != 0) begin
			mismatches += expected_bytes.size();
			$display("%0d expected items never arrived", expected_bytes.size());
		end
		$display("Tone mapped %0d pixels, %0d compared, across 12 exposure settings",
			pixels_accepted, pixels_checked);
		$display("%0d register writes, %0d mismatches", register_writes, mismatches);
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#(2_000_000);
		$display("Timeout waiting for the pipeline to drain");
		$display("Some tests failed");
		$finish;
	end

endmodule
